// ===== hw/rtl/hidden_vector_match_query_defines.svh =====
// Assertion macros for the hidden vector match query block.
`ifndef HIDDEN_VECTOR_MATCH_QUERY_DEFINES_SVH
`define HIDDEN_VECTOR_MATCH_QUERY_DEFINES_SVH
`ifndef ASSERT_OFF
`define HVMQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HVMQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define HVMQ_ASSERT(label, clk, rst_n, prop, msg)
`define HVMQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== hw/rtl/hvmq_pkg.sv =====
`default_nettype none
package hvmq_pkg;
    localparam int MAX_VECTOR_LEN_DEF = 64;
    localparam int NUM_ROUNDS = 10;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_HIGH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_HIGH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POS_SELECT = 3'd4;

    typedef logic [127:0] block_t;

    // token held by one round cell
    typedef struct packed {
        logic   valid;
        block_t state;
        block_t round_key;
        logic [7:0] rcon;
    } round_tok_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] tab [0:255];
        tab = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tab[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/hidden_vector_match_query.sv =====
`default_nettype none
// Channel   | Direction | Handshake        | Payload
// s_axis    | in        | tvalid / tready  | tdata: block_high, block_low; tlast: vector_end
// m_axis    | out       | tvalid / tready  | tdata[0]: matched (bits 7:1 zero)
// cfg       | in        | valid / ready    | index (3 bits), data (64 bits)
//
// One block transfer per cycle while the output is not stalled. The key
// of a vector-end block runs through a key register, ten AES round
// cells of one register each and the output slot, while blocks flow on.
// Reset clears accumulator, position count, registers and all valid bits.
// A stalled output freezes the whole chain; s_axis_tready then falls.
module hidden_vector_match_query
#(
    parameter int MAX_VECTOR_LEN = hvmq_pkg::MAX_VECTOR_LEN_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // block_high [63:0], block_low [127:64]
    input  wire logic         s_axis_tlast,  // vector_end
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [7:0]        m_axis_tdata,  // matched [0], zero fill [7:1]
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [hvmq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]  cfg_data
);
    import hvmq_pkg::*;

    logic [63:0] seed_high_reg, seed_low_reg, check_high_reg, check_low_reg;
    logic [63:0] select_reg;
    logic advance, take;
    round_tok_t chain [NUM_ROUNDS+1];
    logic out_valid_reg;
    logic out_match_reg;

    // Advance the chain whenever the output slot is free or being emptied.
    assign advance = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign take = s_axis_tvalid && advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_high_reg  <= '0;
            seed_low_reg   <= '0;
            check_high_reg <= '0;
            check_low_reg  <= '0;
            select_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SEED_HIGH:  seed_high_reg  <= cfg_data;
                REG_SEED_LOW:   seed_low_reg   <= cfg_data;
                REG_CHECK_HIGH: check_high_reg <= cfg_data;
                REG_CHECK_LOW:  check_low_reg  <= cfg_data;
                REG_POS_SELECT: select_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    hvmq_key_accum #(.MAX_VECTOR_LEN(MAX_VECTOR_LEN)) u_accum
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .advance (advance),
        .blk     ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .last    (s_axis_tlast),
        .select  (select_reg[MAX_VECTOR_LEN-1:0]),
        .seed    ({seed_high_reg, seed_low_reg}),
        .tok_out (chain[0])
    );

    for (genvar g = 0; g < NUM_ROUNDS; g++)
    begin : g_round
        hvmq_round_cell #(.LAST_ROUND(g == NUM_ROUNDS-1)) u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    // Output slot: hold the verdict until the transfer completes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_match_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= chain[NUM_ROUNDS].valid;
            out_match_reg <= chain[NUM_ROUNDS].state == {check_high_reg, check_low_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_match_reg};

    `include "hidden_vector_match_query_defines.svh"
    `HVMQ_ASSERT_NEXT(a_stall_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped under stall")
    `HVMQ_ASSERT(a_no_take_stalled, clk, rst_n, !(m_axis_tvalid && !m_axis_tready && s_axis_tready), "input taken while stalled")
    `HVMQ_ASSERT_NEXT(a_last_enters, clk, rst_n, take && s_axis_tlast, chain[0].valid, "vector end lost")
endmodule
`default_nettype wire

// ===== hw/rtl/hvmq_round_cell.sv =====
`default_nettype none
// One AES round with its key expansion step; a register at the output.
module hvmq_round_cell
#(
    parameter bit LAST_ROUND = 1'b0
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire hvmq_pkg::round_tok_t tok_in,
    output hvmq_pkg::round_tok_t      tok_out
);
    import hvmq_pkg::*;

    logic [7:0] sb [16];
    logic [7:0] sh [16];
    logic [7:0] mc [16];
    logic [7:0] rk [16];
    logic [7:0] rk_next [16];
    block_t state_next;
    block_t key_next;
    logic valid_reg;
    block_t state_reg;
    block_t key_reg;
    logic [7:0] rcon_reg;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            sb[i] = sbox(tok_in.state[8*i +: 8]);
            rk[i] = tok_in.round_key[8*i +: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sh[4*c+r] = sb[4*((c+r)%4)+r];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] all;
            all = sh[4*c] ^ sh[4*c+1] ^ sh[4*c+2] ^ sh[4*c+3];
            mc[4*c]   = sh[4*c]   ^ all ^ xtime(sh[4*c]   ^ sh[4*c+1]);
            mc[4*c+1] = sh[4*c+1] ^ all ^ xtime(sh[4*c+1] ^ sh[4*c+2]);
            mc[4*c+2] = sh[4*c+2] ^ all ^ xtime(sh[4*c+2] ^ sh[4*c+3]);
            mc[4*c+3] = sh[4*c+3] ^ all ^ xtime(sh[4*c+3] ^ sh[4*c]);
        end
        rk_next[0] = rk[0] ^ sbox(rk[13]) ^ tok_in.rcon;
        rk_next[1] = rk[1] ^ sbox(rk[14]);
        rk_next[2] = rk[2] ^ sbox(rk[15]);
        rk_next[3] = rk[3] ^ sbox(rk[12]);
        for (int i = 4; i < 16; i++)
        begin
            rk_next[i] = rk[i] ^ rk_next[i-4];
        end
        for (int i = 0; i < 16; i++)
        begin
            key_next[8*i +: 8]   = rk_next[i];
            state_next[8*i +: 8] = (LAST_ROUND ? sh[i] : mc[i]) ^ rk_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= tok_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
            key_reg   <= key_next;
            rcon_reg  <= xtime(tok_in.rcon);
        end
    end

    assign tok_out = '{valid: valid_reg, state: state_reg, round_key: key_reg, rcon: rcon_reg};
endmodule
`default_nettype wire

// ===== hw/rtl/hvmq_key_accum.sv =====
`default_nettype none
// Accumulate selected blocks; emit the recovered key on the vector's last block.
module hvmq_key_accum
#(
    parameter int MAX_VECTOR_LEN = hvmq_pkg::MAX_VECTOR_LEN_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 take,
    input  wire logic                 advance,
    input  wire hvmq_pkg::block_t     blk,
    input  wire logic                 last,
    input  wire logic [MAX_VECTOR_LEN-1:0] select,
    input  wire hvmq_pkg::block_t     seed,
    output hvmq_pkg::round_tok_t      tok_out
);
    import hvmq_pkg::*;

    localparam int CNT_W = $clog2(MAX_VECTOR_LEN + 1);
    localparam int IDX_W = (MAX_VECTOR_LEN > 1) ? $clog2(MAX_VECTOR_LEN) : 1;

    block_t acc_reg, acc_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic in_range, hit;
    block_t key;
    logic valid_reg;
    block_t key_reg;

    assign in_range = (pos_reg < CNT_W'(MAX_VECTOR_LEN));
    assign hit = in_range && select[pos_reg[IDX_W-1:0]];
    assign key = acc_reg ^ (hit ? blk : '0) ^ seed;

    always_comb
    begin
        acc_next = acc_reg;
        pos_next = pos_reg;
        if (take)
        begin
            if (last)
            begin
                acc_next = '0;
                pos_next = '0;
            end
            else
            begin
                acc_next = acc_reg ^ (hit ? blk : '0);
                pos_next = in_range ? pos_reg + 1'b1 : pos_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
            if (advance)
            begin
                valid_reg <= take && last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_reg <= key;
        end
    end

    assign tok_out = '{valid: valid_reg, state: key_reg, round_key: key_reg, rcon: 8'h01};

    `include "hidden_vector_match_query_defines.svh"
    `HVMQ_ASSERT(a_pos_bound, clk, rst_n, pos_reg <= CNT_W'(MAX_VECTOR_LEN), "position count overran")
    `HVMQ_ASSERT_NEXT(a_end_clears, clk, rst_n, take && last, acc_reg == '0 && pos_reg == '0, "vector end did not clear")
    `HVMQ_ASSERT_NEXT(a_idle_holds, clk, rst_n, !take, $stable(pos_reg) && $stable(acc_reg), "state moved without a transfer")
endmodule
`default_nettype wire
